FILE: hdl/swsm_pkg.sv
// swsm_pkg: shared types and constants of the star wildcard segment matcher
// used by the channel interfaces, the matcher cells, the result queue and the top level
// no dependencies
`default_nettype none

package swsm_pkg;

  // default sizes handed to the top level parameters
  localparam int PATTERN_DEPTH_DEF = 64;
  localparam int SEGMENT_LIMIT_DEF = 32;
  localparam int TEXT_LIMIT_DEF    = 1024;

  // fixed field widths of the channels
  localparam int CMD_W   = 2;
  localparam int SYM_W   = 8;
  localparam int GAP_W   = 10;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 5;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 6;

  // largest value the gap field can carry
  localparam int GAP_FIELD_MAX = 1023;

  // separator byte in the pattern
  localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;

  // result queue depth, a power of two
  localparam int RESULT_FIFO_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_CLEAR   = 2'd2
  } swsm_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NO_MATCH = 2'd0,
    ST_MATCH    = 2'd1,
    ST_OVERFLOW = 2'd2
  } swsm_status_t;

  localparam logic KIND_FIND    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_PATTERN = 3'b001,
    PH_TEXT    = 3'b010,
    PH_DONE    = 3'b100
  } swsm_phase_t;

  typedef struct packed {
    logic               kind;
    logic [GAP_W-1:0]   gap;
    logic [LEN_W-1:0]   segment_length;
    logic [IDX_W-1:0]   segment_index;
    swsm_status_t       status;
    logic [CNT_W-1:0]   segment_count;
    logic               last;
  } swsm_result_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic         wr0;
    logic         wr1;
    swsm_result_t res0;
    swsm_result_t res1;
  } swsm_push_t;

endpackage

`default_nettype wire

FILE: hdl/swsm_channels_if.sv
// swsm_in_if and swsm_out_if: valid/ready channels of the matcher
// depends on swsm_pkg for field widths
`default_nettype none

interface swsm_in_if;
  import swsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SYM_W-1:0] symbol;
  logic             end_of_text;

  modport source (output valid, output command, output symbol, output end_of_text,
                  input ready);
  modport sink   (input valid, input command, input symbol, input end_of_text,
                  output ready);
endinterface

interface swsm_out_if;
  import swsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [GAP_W-1:0]  gap;
  logic [LEN_W-1:0]  segment_length;
  logic [IDX_W-1:0]  segment_index;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  segment_count;
  logic              last;

  modport source (output valid, output kind, output gap, output segment_length,
                  output segment_index, output status, output segment_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input gap, input segment_length,
                  input segment_index, input status, input segment_count,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/star_wildcard_segment_matcher_unit.sv
// Star wildcard segment matcher. A job is loaded as pattern bytes (command pattern),
// then streamed as text bytes (command text); command clear starts a new job.
// Runs of '*' split the pattern into literal segments, found in order, leftmost,
// without overlap. Each find gives a result with the gap since the previous match end
// and the segment length; the byte flagged end_of_text also gives a verdict (match,
// no match, pattern overflow) with the segment count.
// Input channel in_if, result channel out_if, both valid/ready.
// Throughput: one input byte per cycle, pattern or text, while the result queue has
// room. A text byte is checked in the cycle of its transfer by a chain of cells, one
// per pattern position, each passing its partial-match bit to its neighbour; its
// results are written into the result queue, which feeds out_if. A byte may cause
// two results, so a four-entry result queue sits at the output: in_if.ready drops
// while fewer than two entries are free, so a stalled receiver holds off input.
// Reset clears the job state and the queue; pattern and segment storage are left
// as they are and are overwritten by the next pattern.
`default_nettype none

module star_wildcard_segment_matcher_unit #(
  parameter int PATTERN_DEPTH = swsm_pkg::PATTERN_DEPTH_DEF,
  parameter int SEGMENT_LIMIT = swsm_pkg::SEGMENT_LIMIT_DEF,
  parameter int TEXT_LIMIT    = swsm_pkg::TEXT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swsm_in_if.sink    in_if,
  swsm_out_if.source out_if
);
  import swsm_pkg::*;

  localparam int PW        = $clog2(PATTERN_DEPTH);
  localparam int LW        = $clog2(PATTERN_DEPTH + 1);
  localparam int SW        = $clog2(SEGMENT_LIMIT + 1);
  localparam int SAW       = $clog2(SEGMENT_LIMIT);
  localparam int SEG_SLOTS = 1 << SAW;
  localparam int GAP_CAP   = (TEXT_LIMIT - 1 < GAP_FIELD_MAX) ? TEXT_LIMIT - 1
                                                              : GAP_FIELD_MAX;
  localparam int COUNT_CAP = GAP_CAP + PATTERN_DEPTH;
  localparam int BW        = $clog2(COUNT_CAP + 1);

  typedef struct packed {
    logic [PW-1:0] start;
    logic [PW-1:0] last_pos;
    logic [LW-1:0] len;
  } seg_info_t;

  // job state
  logic [LW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] segs_r, segs_nxt;
  logic          star_run_r, star_run_nxt;
  logic          ovf_r, ovf_nxt;
  logic [SW-1:0] cur_seg_r, cur_seg_nxt;
  logic [BW-1:0] bs_r, bs_nxt;
  swsm_phase_t   phase_r, phase_nxt;
  logic [PW-1:0] ld_start_r, ld_start_nxt;
  logic [LW-1:0] ld_len_r, ld_len_nxt;

  // segment table
  seg_info_t     seg_mem [SEG_SLOTS];
  seg_info_t     seg_info_r;
  seg_info_t     tbl_wdata;
  logic          tbl_we;
  logic [SAW-1:0] tbl_waddr, tbl_raddr;

  // decode
  logic accept, pat_cmd, text_cmd, clear_cmd;
  logic pat_acc, step, job_clear, eot;
  logic cell_we, is_star_sym;
  logic [SW-1:0] seg_prev;

  // matcher chain
  logic [PATTERN_DEPTH-1:0] hit_nxt_vec;
  logic [PATTERN_DEPTH-1:0] chain_vec;

  // text side
  logic          seg_active, hit_end, seg_found;
  logic [BW-1:0] bs_inc, gap_raw, gap_sat;
  swsm_status_t  verdict_status;
  swsm_result_t  find_res, verdict_res;
  swsm_push_t    push;
  logic          room;

  assign accept = in_if.valid && in_if.ready;
  assign eot    = in_if.end_of_text;

  always_comb begin
    pat_cmd   = 1'b0;
    text_cmd  = 1'b0;
    clear_cmd = 1'b0;
    unique case (in_if.command)
      CMD_PATTERN: pat_cmd   = 1'b1;
      CMD_TEXT:    text_cmd  = 1'b1;
      CMD_CLEAR:   clear_cmd = 1'b1;
      default: ;
    endcase
  end

  assign pat_acc   = accept && pat_cmd && (phase_r == PH_PATTERN);
  assign step      = accept && text_cmd && (phase_r != PH_DONE);
  assign job_clear = accept && clear_cmd;

  // pattern loading: store bytes, open and extend segments
  assign is_star_sym = (in_if.symbol == STAR_BYTE);
  assign seg_prev    = segs_r - SW'(1);

  always_comb begin
    fill_nxt     = fill_r;
    segs_nxt     = segs_r;
    star_run_nxt = star_run_r;
    ovf_nxt      = ovf_r;
    ld_start_nxt = ld_start_r;
    ld_len_nxt   = ld_len_r;
    cell_we      = 1'b0;
    tbl_we       = 1'b0;
    tbl_waddr    = '0;
    tbl_wdata    = '0;
    if (pat_acc) begin
      if (fill_r >= LW'(PATTERN_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else if (is_star_sym) begin
        cell_we      = 1'b1;
        fill_nxt     = fill_r + LW'(1);
        star_run_nxt = 1'b1;
      end else if (star_run_r && (segs_r >= SW'(SEGMENT_LIMIT))) begin
        ovf_nxt = 1'b1;
      end else begin
        cell_we  = 1'b1;
        fill_nxt = fill_r + LW'(1);
        tbl_we   = 1'b1;
        if (star_run_r) begin
          segs_nxt     = segs_r + SW'(1);
          star_run_nxt = 1'b0;
          ld_start_nxt = fill_r[PW-1:0];
          ld_len_nxt   = LW'(1);
          tbl_waddr    = segs_r[SAW-1:0];
        end else begin
          ld_len_nxt = ld_len_r + LW'(1);
          tbl_waddr  = seg_prev[SAW-1:0];
        end
        tbl_wdata.start    = ld_start_nxt;
        tbl_wdata.last_pos = fill_r[PW-1:0];
        tbl_wdata.len      = ld_len_nxt;
      end
    end
  end

  // segment table, read-first with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      seg_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  assign tbl_raddr = cur_seg_nxt[SAW-1:0];

  always_ff @(posedge clk) begin
    if (tbl_we && (tbl_waddr == tbl_raddr)) begin
      seg_info_r <= tbl_wdata;
    end else begin
      seg_info_r <= seg_mem[tbl_raddr];
    end
  end

  // chain of match cells, one per pattern position
  for (genvar k = 0; k < PATTERN_DEPTH; k++) begin : g_cell
    logic cin;
    if (k == 0) begin : g_first
      assign cin = 1'b0;
    end else begin : g_rest
      assign cin = chain_vec[k-1];
    end
    swsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (job_clear),
      .load_en   (cell_we && (fill_r[PW-1:0] == PW'(k))),
      .load_byte (in_if.symbol),
      .step      (step),
      .text_byte (in_if.symbol),
      .arm       (seg_info_r.start == PW'(k)),
      .chain_in  (cin),
      .chain_out (chain_vec[k]),
      .hit_nxt   (hit_nxt_vec[k])
    );
  end

  // find detection at the last position of the current segment
  assign seg_active = !ovf_r && (cur_seg_r < segs_r);
  assign hit_end    = hit_nxt_vec[seg_info_r.last_pos];
  assign seg_found  = step && seg_active && hit_end;

  assign bs_inc  = (bs_r < BW'(COUNT_CAP)) ? bs_r + BW'(1) : bs_r;
  assign gap_raw = bs_inc - BW'(seg_info_r.len);
  assign gap_sat = (gap_raw > BW'(GAP_CAP)) ? BW'(GAP_CAP) : gap_raw;

  always_comb begin
    cur_seg_nxt = cur_seg_r;
    bs_nxt      = bs_r;
    phase_nxt   = phase_r;
    if (job_clear) begin
      cur_seg_nxt = '0;
    end else if (step) begin
      phase_nxt = eot ? PH_DONE : PH_TEXT;
      if (seg_found) begin
        cur_seg_nxt = cur_seg_r + SW'(1);
        bs_nxt      = '0;
      end else begin
        bs_nxt = bs_inc;
      end
    end
  end

  always_comb begin
    if (ovf_r) begin
      verdict_status = ST_OVERFLOW;
    end else if (cur_seg_nxt >= segs_r) begin
      verdict_status = ST_MATCH;
    end else begin
      verdict_status = ST_NO_MATCH;
    end
  end

  // results of one text byte
  always_comb begin
    find_res                = '0;
    find_res.kind           = KIND_FIND;
    find_res.gap            = GAP_W'(gap_sat);
    find_res.segment_length = LEN_W'(seg_info_r.len);
    find_res.segment_index  = IDX_W'(cur_seg_r);
    find_res.status         = ST_NO_MATCH;
    find_res.last           = !eot;

    verdict_res               = '0;
    verdict_res.kind          = KIND_VERDICT;
    verdict_res.status        = verdict_status;
    verdict_res.segment_count = CNT_W'(segs_r);
    verdict_res.last          = 1'b1;

    push.wr0  = seg_found || (step && eot);
    push.wr1  = seg_found && eot;
    push.res0 = seg_found ? find_res : verdict_res;
    push.res1 = verdict_res;
  end

  // job registers
  always_ff @(posedge clk) begin
    if (!rst_n || job_clear) begin
      fill_r     <= '0;
      segs_r     <= '0;
      star_run_r <= 1'b1;
      ovf_r      <= 1'b0;
      cur_seg_r  <= '0;
      bs_r       <= '0;
      phase_r    <= PH_PATTERN;
    end else begin
      fill_r     <= fill_nxt;
      segs_r     <= segs_nxt;
      star_run_r <= star_run_nxt;
      ovf_r      <= ovf_nxt;
      cur_seg_r  <= cur_seg_nxt;
      bs_r       <= bs_nxt;
      phase_r    <= phase_nxt;
    end
  end

  // open segment bookkeeping
  always_ff @(posedge clk) begin
    ld_start_r <= ld_start_nxt;
    ld_len_r   <= ld_len_nxt;
  end

  swsm_result_fifo u_result_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_if (out_if)
  );

  assign in_if.ready = room;

endmodule

`default_nettype wire

FILE: hdl/swsm_cell.sv
// swsm_cell: one pattern position of the matcher chain
// holds a pattern byte and a partial-match bit handed on to the next cell
// depends on swsm_pkg
`default_nettype none

module swsm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       load_en,
  input  logic [swsm_pkg::SYM_W-1:0] load_byte,
  input  logic                       step,
  input  logic [swsm_pkg::SYM_W-1:0] text_byte,
  input  logic                       arm,
  input  logic                       chain_in,
  output logic                       chain_out,
  output logic                       hit_nxt
);
  import swsm_pkg::*;

  logic [SYM_W-1:0] pat_r;
  logic             star_r;
  logic             hit_r;

  // pattern byte, written once per job
  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_r  <= load_byte;
      star_r <= (load_byte == STAR_BYTE);
    end
  end

  // prefix of the segment matches up to here, started at arm or carried from the left
  assign hit_nxt = (text_byte == pat_r) && !star_r && (arm || chain_in);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hit_r <= 1'b0;
    end else if (step) begin
      hit_r <= hit_nxt;
    end
  end

  assign chain_out = hit_r;

endmodule

`default_nettype wire

FILE: hdl/swsm_result_fifo.sv
// swsm_result_fifo: small result queue between the matcher and the output channel
// takes up to two results per cycle, hands out one per transfer
// depends on swsm_pkg and swsm_out_if
`default_nettype none

module swsm_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swsm_pkg::swsm_push_t push,
  output logic                 room,
  swsm_out_if.source           out_if
);
  import swsm_pkg::*;

  localparam int PTR_W  = $clog2(RESULT_FIFO_DEPTH);
  localparam int FILL_W = $clog2(RESULT_FIFO_DEPTH + 1);

  swsm_result_t      queue_mem [RESULT_FIFO_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [PTR_W-1:0]  head_nxt, tail_nxt;
  logic [FILL_W-1:0] count_r, count_nxt;
  logic              pop;
  swsm_result_t      head_res;

  assign pop = (count_r != '0) && out_if.ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push.wr0) begin
      queue_mem[tail_r] <= push.res0;
    end
    if (push.wr1) begin
      queue_mem[tail_r + PTR_W'(1)] <= push.res1;
    end
  end

  // pointers and fill level
  always_comb begin
    tail_nxt  = tail_r + PTR_W'(push.wr0) + PTR_W'(push.wr1);
    head_nxt  = head_r + PTR_W'(pop);
    count_nxt = count_r + FILL_W'(push.wr0) + FILL_W'(push.wr1) - FILL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // space for the two results one input can cause
  assign room = (count_r <= FILL_W'(RESULT_FIFO_DEPTH - 2));

  // output channel
  assign head_res              = queue_mem[head_r];
  assign out_if.valid          = (count_r != '0);
  assign out_if.kind           = head_res.kind;
  assign out_if.gap            = head_res.gap;
  assign out_if.segment_length = head_res.segment_length;
  assign out_if.segment_index  = head_res.segment_index;
  assign out_if.status         = head_res.status;
  assign out_if.segment_count  = head_res.segment_count;
  assign out_if.last           = head_res.last;

endmodule

`default_nettype wire

FILE: bench/swsm_checker.sv
`timescale 1ns / 100ps
// swsm_checker: watches the input and result channels of the matcher, predicts each
// result from the input transfers and compares them in order
// depends on swsm_pkg and the channel interfaces swsm_in_if and swsm_out_if

module swsm_checker #(
  parameter int PATTERN_DEPTH = swsm_pkg::PATTERN_DEPTH_DEF,
  parameter int SEGMENT_LIMIT = swsm_pkg::SEGMENT_LIMIT_DEF,
  parameter int TEXT_LIMIT    = swsm_pkg::TEXT_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  swsm_in_if   in_ch,
  swsm_out_if  out_ch,
  output int   fail_count,
  output int   awaited
);
  import swsm_pkg::*;

  // gap saturation and the cap of the byte counter behind it
  localparam int GAP_CAP = (TEXT_LIMIT - 1 < GAP_FIELD_MAX) ? TEXT_LIMIT - 1 : GAP_FIELD_MAX;
  localparam int RUN_CAP = GAP_CAP + PATTERN_DEPTH;

  // job state mirrored from the block
  logic [SYM_W-1:0] pat_mem [PATTERN_DEPTH];
  logic [SYM_W-1:0] recent [PATTERN_DEPTH];
  int unsigned      seg_base [SEGMENT_LIMIT];
  int unsigned      seg_len [SEGMENT_LIMIT];
  int unsigned      pat_fill;
  int unsigned      seg_total;
  int unsigned      seg_cursor;
  int unsigned      run_length;
  bit               in_star_run;
  bit               pat_overflow;
  swsm_phase_t      phase;

  // results still to come out of the block, oldest first
  swsm_result_t match_events[$];
  int           mismatches = 0;

  assign fail_count = mismatches;

  task automatic note_failure(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_job();
    for (int k = 0; k < PATTERN_DEPTH; k++) begin
      pat_mem[k] = '0;
      recent[k]  = '0;
    end
    for (int k = 0; k < SEGMENT_LIMIT; k++) begin
      seg_base[k] = 0;
      seg_len[k]  = 0;
    end
    pat_fill     = 0;
    seg_total    = 0;
    seg_cursor   = 0;
    run_length   = 0;
    in_star_run  = 1'b1;
    pat_overflow = 1'b0;
    phase        = PH_PATTERN;
  endfunction

  // one pattern byte: a star closes the open segment, a literal opens or extends one
  function automatic void load_pattern(input logic [SYM_W-1:0] b);
    if (pat_fill >= PATTERN_DEPTH) begin
      pat_overflow = 1'b1;
      return;
    end
    if (b == STAR_BYTE) begin
      pat_mem[pat_fill] = b;
      pat_fill++;
      in_star_run = 1'b1;
      return;
    end
    if (in_star_run) begin
      if (seg_total >= SEGMENT_LIMIT) begin
        pat_overflow = 1'b1;
        return;
      end
      seg_base[seg_total] = pat_fill;
      seg_len[seg_total]  = 0;
      seg_total++;
      in_star_run = 1'b0;
    end
    pat_mem[pat_fill] = b;
    pat_fill++;
    seg_len[seg_total-1]++;
  endfunction

  // exact compare of the newest text bytes against one segment
  function automatic bit window_hit(input int unsigned s);
    int unsigned base;
    int unsigned len;
    int unsigned p;
    base = seg_base[s];
    len  = seg_len[s];
    if (len == 0 || len > PATTERN_DEPTH) return 1'b0;
    for (int unsigned k = 0; k < len; k++) begin
      p = base + k;
      if (p >= PATTERN_DEPTH) return 1'b0;
      if (recent[len-1-k] != pat_mem[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one text byte: shift it in, look for the current segment, close the job on end of text
  function automatic void take_text(input logic [SYM_W-1:0] sym, input logic eot);
    swsm_result_t find;
    swsm_result_t verdict;
    int unsigned  len;
    int unsigned  gap;
    find    = '0;
    verdict = '0;
    phase   = PH_TEXT;
    for (int k = PATTERN_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = sym;
    if (run_length < RUN_CAP) run_length++;

    if (!pat_overflow && seg_cursor < seg_total) begin
      len = seg_len[seg_cursor];
      if (run_length >= len && window_hit(seg_cursor)) begin
        gap = run_length - len;
        if (gap > GAP_CAP) gap = GAP_CAP;
        find.kind           = KIND_FIND;
        find.gap            = gap[GAP_W-1:0];
        find.segment_length = len[LEN_W-1:0];
        find.segment_index  = seg_cursor[IDX_W-1:0];
        find.status         = ST_NO_MATCH;
        find.last           = !eot;
        match_events.push_back(find);
        seg_cursor++;
        run_length = 0;
      end
    end

    if (eot) begin
      verdict.kind          = KIND_VERDICT;
      verdict.status        = pat_overflow ? ST_OVERFLOW
                            : (seg_cursor >= seg_total ? ST_MATCH : ST_NO_MATCH);
      verdict.segment_count = seg_total[CNT_W-1:0];
      verdict.last          = 1'b1;
      match_events.push_back(verdict);
      phase = PH_DONE;
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) note_failure($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic check_result();
    swsm_result_t want;
    if (match_events.size() == 0) begin
      note_failure($sformatf("result with nothing expected (kind %0d, index %0d, status %0d)",
                             out_ch.kind, out_ch.segment_index, out_ch.status));
      return;
    end
    want = match_events.pop_front();
    check_field("kind", 16'(out_ch.kind), 16'(want.kind));
    check_field("gap", 16'(out_ch.gap), 16'(want.gap));
    check_field("segment_length", 16'(out_ch.segment_length), 16'(want.segment_length));
    check_field("segment_index", 16'(out_ch.segment_index), 16'(want.segment_index));
    check_field("status", 16'(out_ch.status), 16'(want.status));
    check_field("segment_count", 16'(out_ch.segment_count), 16'(want.segment_count));
    check_field("last", 16'(out_ch.last), 16'(want.last));
  endtask

  // input transfers feed the prediction first, then any result transfer is checked
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_job();
      match_events.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_CLEAR:   clear_job();
          CMD_PATTERN: if (phase == PH_PATTERN) load_pattern(in_ch.symbol);
          CMD_TEXT:    if (phase != PH_DONE) take_text(in_ch.symbol, in_ch.end_of_text);
          default:     ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    awaited <= match_events.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for star_wildcard_segment_matcher_unit
// depends on swsm_pkg, the channel interfaces and swsm_checker, which does all checking

module tb;
  import swsm_pkg::*;

  // command value that the block ignores
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  localparam int ITEM_TARGET = 1800;
  localparam int IDLE_PCT    = 31;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN       = 16;

  typedef enum int {JOB_PLAIN, JOB_FULL, JOB_OVERFLOW, JOB_LONG, JOB_NOISE} job_shape_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   awaited;
  int   cycles = 0;
  int   items_done = 0;
  bit   calm = 1'b0;

  swsm_in_if  in_ch ();
  swsm_out_if out_ch ();

  star_wildcard_segment_matcher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  swsm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result receiver stalls at random, never during the calm stretch
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic push_byte(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic eot, input bit counted);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.symbol      <= sym;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (counted) items_done++;
    calm = (items_done >= 700 && items_done < 1000);
  endtask

  // literal bytes for segments: mostly a small alphabet, never a star
  function automatic logic [SYM_W-1:0] seg_symbol();
    logic [SYM_W-1:0] b;
    if ($urandom_range(99) < 85) begin
      b = 8'h61 + SYM_W'($urandom_range(2));
    end else begin
      b = SYM_W'($urandom_range(255));
      if (b == STAR_BYTE) b = 8'hFF;
    end
    return b;
  endfunction

  // filler text: same alphabet, sometimes any byte at all
  function automatic logic [SYM_W-1:0] text_symbol();
    if ($urandom_range(99) < 80) return 8'h61 + SYM_W'($urandom_range(2));
    return SYM_W'($urandom_range(255));
  endfunction

  // one job: clear, pattern, text built around the segments, stray items
  task automatic run_job(input job_shape_t shape);
    logic [SYM_W-1:0] seg_bytes[$];
    logic [SYM_W-1:0] txt[$];
    logic [SYM_W-1:0] b;
    int               seg_lens[$];
    int               nseg;
    int               len;
    int               pos;
    int               lead;
    if (shape == JOB_NOISE) begin
      repeat ($urandom_range(10, 30))
        push_byte(CMD_W'($urandom_range(3)), SYM_W'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0);
      return;
    end
    push_byte(CMD_CLEAR, SYM_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);

    // pattern
    case (shape)
      JOB_FULL: begin
        repeat (PATTERN_DEPTH_DEF) begin
          b = seg_symbol();
          seg_bytes.push_back(b);
          push_byte(CMD_PATTERN, b, 1'($urandom_range(1)), 1'b1);
        end
        seg_lens.push_back(PATTERN_DEPTH_DEF);
      end
      JOB_OVERFLOW: begin
        repeat ($urandom_range(PATTERN_DEPTH_DEF + 1, PATTERN_DEPTH_DEF + 8)) begin
          b = ($urandom_range(3) == 0) ? STAR_BYTE : seg_symbol();
          push_byte(CMD_PATTERN, b, 1'($urandom_range(1)), 1'b1);
        end
      end
      default: begin
        nseg = (shape == JOB_LONG) ? $urandom_range(1, 3) : $urandom_range(0, 5);
        if ($urandom_range(1))
          repeat ($urandom_range(1, 2)) push_byte(CMD_PATTERN, STAR_BYTE, 1'b0, 1'b1);
        for (int s = 0; s < nseg; s++) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
          seg_lens.push_back(len);
          repeat (len) begin
            b = seg_symbol();
            seg_bytes.push_back(b);
            push_byte(CMD_PATTERN, b, 1'($urandom_range(1)), 1'b1);
          end
          if (s < nseg - 1 || $urandom_range(1))
            repeat ($urandom_range(1, 2))
              push_byte(CMD_PATTERN, STAR_BYTE, 1'($urandom_range(1)), 1'b1);
        end
      end
    endcase

    // text: filler, then each segment, sometimes left out or spoilt by one byte
    pos = 0;
    foreach (seg_lens[s]) begin
      if ((shape == JOB_LONG && s == 0) || $urandom_range(99) < 85) begin
        lead = (shape == JOB_LONG && s == 0) ? $urandom_range(1030, 1100) : $urandom_range(0, 6);
        repeat (lead) txt.push_back(text_symbol());
        for (int k = 0; k < seg_lens[s]; k++) txt.push_back(seg_bytes[pos+k]);
        if ($urandom_range(9) == 0)
          txt[txt.size() - 1 - $urandom_range(0, seg_lens[s] - 1)] ^= 8'h01;
      end
      pos += seg_lens[s];
    end
    repeat ((shape == JOB_OVERFLOW) ? $urandom_range(5, 20) : $urandom_range(0, 5))
      txt.push_back(text_symbol());
    if (txt.size() == 0) txt.push_back(text_symbol());

    // stray pattern bytes and ignored commands only once text has begun
    foreach (txt[k]) begin
      if (k > 0 && $urandom_range(99) < 4)
        push_byte($urandom_range(1) ? CMD_PATTERN : CMD_IGNORED, SYM_W'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0);
      push_byte(CMD_TEXT, txt[k], k == txt.size() - 1, 1'b1);
    end

    // items after the verdict, all ignored
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3))
        push_byte($urandom_range(1) ? CMD_TEXT : ($urandom_range(1) ? CMD_PATTERN : CMD_IGNORED),
                  SYM_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
  endtask

  // stimulus and verdict
  initial begin
    job_shape_t shape;
    int         job;
    int         pick;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_CLEAR;
    in_ch.symbol      <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pattern matches, then text after the verdict and an ignored command
    push_byte(CMD_TEXT, 8'hFF, 1'b1, 1'b1);
    push_byte(CMD_TEXT, 8'h78, 1'b0, 1'b0);
    push_byte(CMD_IGNORED, 8'h00, 1'b1, 1'b0);

    // leading star, second segment would overlap the first match: no match
    push_byte(CMD_CLEAR, 8'h00, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, STAR_BYTE, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h61, 1'b1, 1'b1);
    push_byte(CMD_PATTERN, 8'h62, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, STAR_BYTE, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h62, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h62, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h61, 1'b1, 1'b1);
    push_byte(CMD_PATTERN, 8'h71, 1'b0, 1'b0);

    // overlapping prefix "aab" in "aaab", pattern byte after text began
    push_byte(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
    push_byte(CMD_PATTERN, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h62, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_PATTERN, 8'h62, 1'b0, 1'b0);
    push_byte(CMD_TEXT, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h61, 1'b0, 1'b1);
    push_byte(CMD_TEXT, 8'h62, 1'b1, 1'b1);

    // random jobs, the rare shapes forced early
    items_done = 0;
    job = 0;
    while (items_done < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (job == 0) shape = JOB_FULL;
      else if (job == 1) shape = JOB_OVERFLOW;
      else if (job == 3) shape = JOB_LONG;
      else if (pick < 10) shape = JOB_NOISE;
      else if (pick < 15) shape = JOB_OVERFLOW;
      else if (pick < 18) shape = JOB_FULL;
      else shape = JOB_PLAIN;
      run_job(shape);
      job++;
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
